>>> rtl/lbca_pkg.sv
`timescale 1ns / 1ps

package lbca_pkg;

  localparam int unsigned HIT_LIMIT = 20;
  localparam int unsigned HIT_W = 5;
  localparam int unsigned EVICT_MAX = 31;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_HIT,
    OP_DROP,
    OP_PLACE,
    OP_MISS
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic last;
    logic match;
    logic short_space;
    logic empty;
  } status_t;

endpackage

>>> rtl/lbca_ctrl.sv
`timescale 1ns / 1ps

module lbca_ctrl #(
  parameter int unsigned IW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        cache_enable_i,
  input  logic                        no_evict_i,
  input  lbca_pkg::status_t           status_i,
  input  logic [lbca_pkg::HIT_W-1:0]  rd_hits_i,
  output lbca_pkg::cmd_t              cmd_o,
  output logic [IW-1:0]               idx_o,
  output logic [IW-1:0]               pick_o,
  output logic                        busy,
  output logic                        done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MISS,
    ST_SCAN,
    ST_DROP
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d, pick_q, pick_d;
  logic [lbca_pkg::HIT_W-1:0] best_q, best_d;
  logic en_q, en_d, keep_q, keep_d, done_q, done_d;
  lbca_pkg::cmd_t cmd;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pick_d  = pick_q;
    best_d  = best_q;
    en_d    = en_q;
    keep_d  = keep_q;
    done_d  = 1'b0;
    cmd.op  = lbca_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd.op  = lbca_pkg::OP_LATCH;
          en_d    = cache_enable_i;
          keep_d  = no_evict_i;
          idx_d   = '0;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status_i.at_end) begin
          state_d = ST_MISS;
        end else if (status_i.match) begin
          cmd.op  = lbca_pkg::OP_HIT;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.last) begin
          state_d = ST_MISS;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_MISS: begin
        if (!en_q) begin
          cmd.op  = lbca_pkg::OP_MISS;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (!keep_q && status_i.short_space && !status_i.empty) begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end else begin
          cmd.op  = lbca_pkg::OP_PLACE;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (idx_q == '0 || rd_hits_i < best_q) begin
          pick_d = idx_q;
          best_d = rd_hits_i;
        end
        if (status_i.last) begin
          state_d = ST_DROP;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_DROP: begin
        cmd.op  = lbca_pkg::OP_DROP;
        state_d = ST_MISS;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      pick_q  <= '0;
      best_q  <= '0;
      en_q    <= 1'b0;
      keep_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pick_q  <= pick_d;
      best_q  <= best_d;
      en_q    <= en_d;
      keep_q  <= keep_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o  = cmd;
  assign idx_o  = idx_q;
  assign pick_o = pick_q;
  assign busy   = (state_q != ST_IDLE);
  assign done   = done_q;

endmodule

>>> rtl/lbca_datapath.sv
`timescale 1ns / 1ps

module lbca_datapath #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW = 4,
  parameter int unsigned CW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  lbca_pkg::cmd_t              cmd_i,
  input  logic [IW-1:0]               idx_i,
  input  logic [IW-1:0]               pick_i,
  input  logic [31:0]                 item_key_i,
  input  logic [31:0]                 item_length_i,
  output lbca_pkg::status_t           status_o,
  output logic [lbca_pkg::HIT_W-1:0]  rd_hits_o,
  output logic                        was_hit_o,
  output logic                        was_stored_o,
  output logic [31:0]                 base_offset_o,
  output logic [31:0]                 found_length_o,
  output logic [4:0]                  evicted_count_o
);

  logic [31:0] key_q [ENTRIES];
  logic [31:0] len_q [ENTRIES];
  logic [31:0] off_q [ENTRIES];
  logic [lbca_pkg::HIT_W-1:0] hits_q [ENTRIES];
  logic [CW-1:0] count_q;
  logic [31:0] free_q, top_q;
  logic [31:0] req_key_q, req_len_q;
  logic hit_q, stored_q;
  logic [31:0] res_off_q, res_len_q;
  logic [4:0] evict_q;
  logic [31:0] drop_len;
  logic room;
  logic [IW-1:0] ins;

  assign drop_len = len_q[pick_i];
  assign ins      = count_q[IW-1:0];
  assign room     = (count_q != CW'(ENTRIES)) && (req_len_q != '0) && (free_q >= req_len_q);

  always_comb begin
    status_o.at_end      = (CW'(idx_i) >= count_q);
    status_o.last        = (CW'(CW'(idx_i) + CW'(1)) >= count_q);
    status_o.match       = (key_q[idx_i] == req_key_q);
    status_o.short_space = (free_q < req_len_q);
    status_o.empty       = (count_q == '0);
  end
  assign rd_hits_o = hits_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      free_q  <= 32'd1048576;
      top_q   <= '0;
    end else if (cfg_we_i) begin
      count_q <= '0;
      free_q  <= cfg_wdata_i;
      top_q   <= '0;
    end else begin
      case (cmd_i.op)
        lbca_pkg::OP_DROP: begin
          count_q <= count_q - CW'(1);
          free_q  <= free_q + drop_len;
          top_q   <= top_q - drop_len;
        end
        lbca_pkg::OP_PLACE: begin
          if (room) begin
            count_q <= count_q + CW'(1);
            free_q  <= free_q - req_len_q;
            top_q   <= top_q + req_len_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lbca_pkg::OP_LATCH: begin
        req_key_q <= item_key_i;
        req_len_q <= item_length_i;
        evict_q   <= '0;
      end
      lbca_pkg::OP_HIT: begin
        if (hits_q[idx_i] < lbca_pkg::HIT_W'(lbca_pkg::HIT_LIMIT)) begin
          hits_q[idx_i] <= hits_q[idx_i] + lbca_pkg::HIT_W'(1);
        end
        hit_q     <= 1'b1;
        stored_q  <= 1'b0;
        res_off_q <= off_q[idx_i];
        res_len_q <= len_q[idx_i];
        evict_q   <= '0;
      end
      lbca_pkg::OP_DROP: begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (IW'(j) < pick_i) begin
            if (hits_q[j] != '0) hits_q[j] <= hits_q[j] - lbca_pkg::HIT_W'(1);
          end else if (j < ENTRIES - 1) begin
            key_q[j] <= key_q[j+1];
            len_q[j] <= len_q[j+1];
            off_q[j] <= off_q[j+1] - drop_len;
            if (hits_q[j+1] != '0) hits_q[j] <= hits_q[j+1] - lbca_pkg::HIT_W'(1);
            else hits_q[j] <= '0;
          end
        end
        if (evict_q != 5'(lbca_pkg::EVICT_MAX)) evict_q <= evict_q + 5'd1;
      end
      lbca_pkg::OP_PLACE: begin
        hit_q <= 1'b0;
        if (room) begin
          key_q[ins]  <= req_key_q;
          len_q[ins]  <= req_len_q;
          off_q[ins]  <= top_q;
          hits_q[ins] <= '0;
          stored_q    <= 1'b1;
          res_off_q   <= top_q;
          res_len_q   <= req_len_q;
        end else begin
          stored_q  <= 1'b0;
          res_off_q <= '0;
          res_len_q <= '0;
        end
      end
      lbca_pkg::OP_MISS: begin
        hit_q     <= 1'b0;
        stored_q  <= 1'b0;
        res_off_q <= '0;
        res_len_q <= '0;
      end
      default: ;
    endcase
  end

  assign was_hit_o       = hit_q;
  assign was_stored_o    = stored_q;
  assign base_offset_o   = res_off_q;
  assign found_length_o  = res_len_q;
  assign evicted_count_o = evict_q;

endmodule

>>> rtl/lfu_block_cache_allocator_core.sv
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; done pulses for one cycle with the result.
// A lookup walks the valid entries through one shared key compare (an empty table goes straight
// to the miss path), and each eviction walks the valid entries again to pick the least-used one.
// The next request may start in the cycle that done is high. The receiver cannot stall.
// Reset and any pool size write empty the table, set free bytes to the pool size and top to 0.
module lfu_block_cache_allocator_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] item_key_i,
  input  logic [31:0] item_length_i,
  input  logic        cache_enable_i,
  input  logic        no_evict_i,
  output logic        done,
  output logic        was_hit_o,
  output logic        was_stored_o,
  output logic [31:0] base_offset_o,
  output logic [31:0] found_length_o,
  output logic [4:0]  evicted_count_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  lbca_pkg::cmd_t cmd;
  lbca_pkg::status_t status;
  logic [IW-1:0] idx, pick;
  logic [lbca_pkg::HIT_W-1:0] rd_hits;

  lbca_ctrl #(.IW(IW)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cache_enable_i (cache_enable_i),
    .no_evict_i     (no_evict_i),
    .status_i       (status),
    .rd_hits_i      (rd_hits),
    .cmd_o          (cmd),
    .idx_o          (idx),
    .pick_o         (pick),
    .busy           (busy),
    .done           (done)
  );

  lbca_datapath #(.ENTRIES(ENTRIES), .IW(IW), .CW(CW)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .idx_i           (idx),
    .pick_i          (pick),
    .item_key_i      (item_key_i),
    .item_length_i   (item_length_i),
    .status_o        (status),
    .rd_hits_o       (rd_hits),
    .was_hit_o       (was_hit_o),
    .was_stored_o    (was_stored_o),
    .base_offset_o   (base_offset_o),
    .found_length_o  (found_length_o),
    .evicted_count_o (evicted_count_o)
  );

endmodule

>>> tb/sv/lfu_cache_checker.sv
`timescale 1ns / 1ps

module lfu_cache_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] item_key_i,
  input  logic [31:0] item_length_i,
  input  logic        cache_enable_i,
  input  logic        no_evict_i,
  input  logic        done,
  input  logic        was_hit_i,
  input  logic        was_stored_i,
  input  logic [31:0] base_offset_i,
  input  logic [31:0] found_length_i,
  input  logic [4:0]  evicted_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        hit;
    logic        stored;
    logic [31:0] offset;
    logic [31:0] length;
    logic [4:0]  evicted;
  } lookup_res_t;

  logic [31:0]                pool_size;
  logic [31:0]                tag_q [ENTRIES];
  logic [31:0]                len_q [ENTRIES];
  logic [31:0]                off_q [ENTRIES];
  logic [lbca_pkg::HIT_W-1:0] uses_q [ENTRIES];
  logic [31:0]                free_q;
  logic [31:0]                top_q;
  lookup_res_t                awaited [$];

  assign pending_o = awaited.size();

  function automatic void empty_pool();
    for (int i = 0; i < ENTRIES; i++) begin
      tag_q[i] = '0;
      len_q[i] = '0;
      off_q[i] = '0;
      uses_q[i] = '0;
    end
    free_q = pool_size;
    top_q = '0;
  endfunction

  function automatic bit evict_least_used();
    int pick;
    logic [31:0] gap;
    pick = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (len_q[i] != 0 && (pick < 0 || uses_q[i] < uses_q[pick])) pick = i;
    end
    if (pick < 0) return 0;
    gap = len_q[pick];
    free_q += gap;
    top_q -= gap;
    for (int j = pick; j < ENTRIES - 1; j++) begin
      tag_q[j] = tag_q[j + 1];
      len_q[j] = len_q[j + 1];
      off_q[j] = off_q[j + 1] - gap;
      uses_q[j] = uses_q[j + 1];
    end
    len_q[ENTRIES - 1] = '0;
    uses_q[ENTRIES - 1] = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (uses_q[i] > 0) uses_q[i] = uses_q[i] - lbca_pkg::HIT_W'(1);
    end
    return 1;
  endfunction

  function automatic lookup_res_t serve_request(logic [31:0] key, logic [31:0] len,
                                                logic en, logic keep);
    lookup_res_t r;
    int slot;
    r = '0;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (len_q[i] != 0 && tag_q[i] == key) begin
        slot = i;
        break;
      end
    end
    if (slot >= 0) begin
      if (uses_q[slot] < lbca_pkg::HIT_LIMIT) begin
        uses_q[slot] = uses_q[slot] + lbca_pkg::HIT_W'(1);
      end
      r.hit = 1'b1;
      r.offset = off_q[slot];
      r.length = len_q[slot];
    end else if (en) begin
      if (!keep) begin
        while (free_q < len) begin
          if (!evict_least_used()) break;
          if (r.evicted < lbca_pkg::EVICT_MAX) r.evicted = r.evicted + 5'd1;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (len_q[i] == 0) begin
          slot = i;
          break;
        end
      end
      if (slot >= 0 && len != 0 && free_q >= len) begin
        tag_q[slot] = key;
        len_q[slot] = len;
        off_q[slot] = top_q;
        uses_q[slot] = '0;
        r.stored = 1'b1;
        r.offset = top_q;
        r.length = len;
        free_q -= len;
        top_q += len;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t want;
    if (!rst_ni) begin
      pool_size = 32'd1048576;
      empty_pool();
      awaited.delete();
      fail_count_o = 0;
    end else begin
      if (done) begin
        if (awaited.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count_o++;
        end else begin
          want = awaited.pop_front();
          if (was_hit_i !== want.hit) begin
            $error("was_hit: expected %0d, got %0d", want.hit, was_hit_i);
            fail_count_o++;
          end
          if (was_stored_i !== want.stored) begin
            $error("was_stored: expected %0d, got %0d", want.stored, was_stored_i);
            fail_count_o++;
          end
          if (base_offset_i !== want.offset) begin
            $error("base_offset: expected %0h, got %0h", want.offset, base_offset_i);
            fail_count_o++;
          end
          if (found_length_i !== want.length) begin
            $error("found_length: expected %0h, got %0h", want.length, found_length_i);
            fail_count_o++;
          end
          if (evicted_count_i !== want.evicted) begin
            $error("evicted_count: expected %0d, got %0d", want.evicted, evicted_count_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        pool_size = cfg_wdata_i;
        empty_pool();
      end
      if (start && !busy) begin
        awaited.push_back(serve_request(item_key_i, item_length_i,
                                        cache_enable_i, no_evict_i));
      end
    end
  end

endmodule

>>> tb/sv/lfu_block_cache_allocator_core_test.sv
`timescale 1ns / 1ps

module lfu_block_cache_allocator_core_test;

  localparam int unsigned WATCH_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] item_key_i = '0;
  logic [31:0] item_length_i = '0;
  logic        cache_enable_i = 1'b0;
  logic        no_evict_i = 1'b0;
  logic        done;
  logic        was_hit_o;
  logic        was_stored_o;
  logic [31:0] base_offset_o;
  logic [31:0] found_length_o;
  logic [4:0]  evicted_count_o;
  int          fail_count;
  int          pending;
  int          gap_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] pool_now = 32'd1048576;
  logic [31:0] key_set [24];

  lfu_block_cache_allocator_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy), .item_key_i(item_key_i), .item_length_i(item_length_i),
    .cache_enable_i(cache_enable_i), .no_evict_i(no_evict_i), .done(done),
    .was_hit_o(was_hit_o), .was_stored_o(was_stored_o), .base_offset_o(base_offset_o),
    .found_length_o(found_length_o), .evicted_count_o(evicted_count_o)
  );

  lfu_cache_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy), .item_key_i(item_key_i), .item_length_i(item_length_i),
    .cache_enable_i(cache_enable_i), .no_evict_i(no_evict_i), .done(done),
    .was_hit_i(was_hit_o), .was_stored_i(was_stored_o), .base_offset_i(base_offset_o),
    .found_length_i(found_length_o), .evicted_count_i(evicted_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done || (pending == 0 && !start)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic request(logic [31:0] key, logic [31:0] len, logic en, logic keep);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    item_key_i <= key;
    item_length_i <= len;
    cache_enable_i <= en;
    no_evict_i <= keep;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_pool(logic [31:0] size);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    pool_now = size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return $urandom();
    if (r < 8) return '0;
    if (pool_now == 0) return $urandom_range(8, 1);
    if (pool_now > 32'h0100_0000) return $urandom_range(32'h0400_0000, 1) << $urandom_range(5);
    return $urandom_range(pool_now / 3 + 1, 1);
  endfunction

  initial begin
    logic [31:0] pools [6];
    int          phase_gap [4];
    pools = '{32'd1048576, 32'd0, 32'hFFFF_FFFF, 32'd100, 32'd1000, 32'd20000};
    phase_gap = '{0, 53, 27, 53};
    key_set[0] = '0;
    key_set[1] = '1;
    for (int i = 2; i < 24; i++) key_set[i] = $urandom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    request(32'h0, 32'd10, 1'b1, 1'b0);
    request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    request(32'h0, 32'd5, 1'b0, 1'b0);
    request(32'h1234_5678, 32'd0, 1'b1, 1'b0);
    request(32'h1111, 32'd64, 1'b0, 1'b0);
    for (int i = 0; i < 17; i++) request(32'hA000 + i, 32'd1000 + i, 1'b1, 1'b0);
    request(32'hA003, 32'd1, 1'b1, 1'b1);
    request(32'hBEEF, 32'd1048576, 1'b1, 1'b1);
    request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);

    for (int p = 0; p < 12; p++) begin
      write_pool(pools[p % 6]);
      gap_pct = phase_gap[p % 4];
      for (int n = 0; n < 145; n++) begin
        request(key_set[$urandom_range(23)], pick_length(),
                $urandom_range(9) != 0, $urandom_range(5) == 0);
      end
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lbca_pkg.sv
rtl/lbca_ctrl.sv
rtl/lbca_datapath.sv
rtl/lfu_block_cache_allocator_core.sv
tb/sv/lfu_cache_checker.sv
tb/sv/lfu_block_cache_allocator_core_test.sv
